>>> sv/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CAP_W-1:0]         cap_type;

   localparam logic     MODE_GET  = 1'b0;
   localparam logic     MODE_PUT  = 1'b1;
   localparam data_type READ_MISS = -32'sd1;
   localparam cap_type  CAP_RESET = 5'd16;

   typedef struct packed {
      logic     mode;
      data_type key;
      data_type value_in;
   } req_type;

   typedef struct packed {
      logic     hit;
      data_type read_value;
      logic     evicted;
      data_type evicted_key;
   } rsp_type;

endpackage

>>> sv/lkv_req_if.sv
// Request channel: one get or put operation per beat.
`timescale 1ns / 1ps

interface lkv_req_if;
   import lkv_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/lkv_rsp_if.sv
// Response channel: one result per beat.
`timescale 1ns / 1ps

interface lkv_rsp_if;
   import lkv_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/lkv_csr_if.sv
// Configuration write channel carrying the capacity register.
`timescale 1ns / 1ps

interface lkv_csr_if;
   import lkv_pkg::*;

   logic    valid;
   logic    ready;
   cap_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/lru_key_value_cache.sv
// Fully associative key/value cache with true LRU replacement.
//
//   channel   dir   beat contents                          accepted when
//   req_if    in    mode, key, value_in                    valid && ready
//   rsp_if    out   hit, read_value, evicted, evicted_key  valid && ready
//   csr_if    in    capacity_in_use                        valid && ready
//
// A hit or a put, from request beat to response beat, makes one pass over the
// key/value/rank memories, one entry a cycle, that finds the key, a free slot
// and the LRU entry; a second pass zeroes the target's rank and adds one to each
// valid rank below its old one (all, on an insert); a get that misses skips it.
// Synchronous reset clears state, valid bits and count; capacity resets to 16.
// A stalled response holds in the output register while the next request scans.
`timescale 1ns / 1ps

module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   lkv_req_if.sink    req_if,
   lkv_rsp_if.source  rsp_if,
   lkv_csr_if.sink    csr_if
);
   import lkv_pkg::*;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_RANK   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   // storage
   data_type          key_mem  [ENTRIES];
   data_type          val_mem  [ENTRIES];
   logic [RANK_W-1:0] rank_mem [ENTRIES];
   data_type          key_rd_ff;
   data_type          val_rd_ff;
   logic [RANK_W-1:0] rank_rd_ff;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   req_type            op_ff, op_in;
   cap_type            cap_ff, cap_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               match_ff, match_in;
   logic [IDX_W-1:0]   match_slot_ff, match_slot_in;
   logic [RANK_W-1:0]  match_rank_ff, match_rank_in;
   data_type           match_val_ff, match_val_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_slot_ff, free_slot_in;
   logic               lru_ff, lru_in;
   logic [IDX_W-1:0]   lru_slot_ff, lru_slot_in;
   logic [RANK_W-1:0]  lru_rank_ff, lru_rank_in;
   data_type           lru_key_ff, lru_key_in;

   logic               touch_ff, touch_in;
   logic [IDX_W-1:0]   tgt_ff, tgt_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               issue;
   logic               mem_re;
   logic [IDX_W-1:0]   rd_addr;
   logic               key_we, val_we, rank_we;
   logic [IDX_W-1:0]   wr_slot;
   logic [RANK_W-1:0]  rank_wdata;
   logic [CMP_W-1:0]   eff_cap;
   logic               use_free;
   logic [IDX_W-1:0]   ins_slot;
   logic               scan_last;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // zero acts as one, anything above the store size acts as the store size
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign issue     = ((state_ff == S_SCAN) || (state_ff == S_RANK)) &&
                      (cnt_ff < CNT_W'(ENTRIES));
   assign scan_last = (cnt_ff == CNT_W'(ENTRIES));
   assign use_free  = (CMP_W'(count_ff) < eff_cap) && free_ff;
   assign ins_slot  = use_free ? free_slot_ff : (lru_ff ? lru_slot_ff : '0);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      cap_in        = cap_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      match_slot_in = match_slot_ff;
      match_rank_in = match_rank_ff;
      match_val_in  = match_val_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      lru_in        = lru_ff;
      lru_slot_in   = lru_slot_ff;
      lru_rank_in   = lru_rank_ff;
      lru_key_in    = lru_key_ff;
      touch_in      = touch_ff;
      tgt_in        = tgt_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      rank_we       = 1'b0;
      wr_slot       = '0;
      rank_wdata    = '0;

      mem_re    = issue;
      rd_addr   = cnt_ff[IDX_W-1:0];
      rd_vld_in = issue;
      rd_idx_in = cnt_ff[IDX_W-1:0];
      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (csr_if.valid) begin
         cap_in = csr_if.data;
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.data;
               cnt_in   = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               lru_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (valid_ff[rd_idx_ff] && (key_rd_ff == op_ff.key) && !match_ff) begin
                  match_in      = 1'b1;
                  match_slot_in = rd_idx_ff;
                  match_rank_in = rank_rd_ff;
                  match_val_in  = val_rd_ff;
               end
               if (!valid_ff[rd_idx_ff] && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = rd_idx_ff;
               end
               // first entry of the highest rank wins
               if (valid_ff[rd_idx_ff] && (!lru_ff || (rank_rd_ff > lru_rank_ff))) begin
                  lru_in      = 1'b1;
                  lru_slot_in = rd_idx_ff;
                  lru_rank_in = rank_rd_ff;
                  lru_key_in  = key_rd_ff;
               end
            end
            if (scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cnt_in                = '0;
            res_in.hit            = match_ff;
            res_in.read_value     = READ_MISS;
            res_in.evicted        = 1'b0;
            res_in.evicted_key    = '0;
            touch_in              = 1'b1;
            tgt_in                = match_slot_ff;
            if (op_ff.mode == MODE_GET) begin
               if (match_ff) begin
                  res_in.read_value = match_val_ff;
                  state_in          = S_RANK;
               end else begin
                  state_in = S_DONE;
               end
            end else if (match_ff) begin
               val_we   = 1'b1;
               wr_slot  = match_slot_ff;
               state_in = S_RANK;
            end else begin
               key_we   = 1'b1;
               val_we   = 1'b1;
               wr_slot  = ins_slot;
               touch_in = 1'b0;
               tgt_in   = ins_slot;
               valid_in[ins_slot] = 1'b1;
               // an eviction frees the slot it reuses: count holds
               if (!use_free && lru_ff) begin
                  res_in.evicted     = 1'b1;
                  res_in.evicted_key = lru_key_ff;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_RANK;
            end
         end
         S_RANK: begin
            if (rd_vld_ff) begin
               if (rd_idx_ff == tgt_ff) begin
                  rank_we    = 1'b1;
                  rank_wdata = '0;
               end else if (valid_ff[rd_idx_ff] &&
                            (!touch_ff || (rank_rd_ff < match_rank_ff))) begin
                  rank_we    = 1'b1;
                  rank_wdata = rank_rd_ff + RANK_W'(1);
               end
            end
            if (scan_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         cap_ff       <= CAP_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      op_ff         <= op_in;
      match_ff      <= match_in;
      match_slot_ff <= match_slot_in;
      match_rank_ff <= match_rank_in;
      match_val_ff  <= match_val_in;
      free_ff       <= free_in;
      free_slot_ff  <= free_slot_in;
      lru_ff        <= lru_in;
      lru_slot_ff   <= lru_slot_in;
      lru_rank_ff   <= lru_rank_in;
      lru_key_ff    <= lru_key_in;
      touch_ff      <= touch_in;
      tgt_ff        <= tgt_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // memories: one read and one write per cycle each, read data registered
   always_ff @(posedge clock) begin
      if (mem_re) begin
         key_rd_ff  <= key_mem[rd_addr];
         val_rd_ff  <= val_mem[rd_addr];
         rank_rd_ff <= rank_mem[rd_addr];
      end
      if (key_we) begin
         key_mem[wr_slot] <= op_ff.key;
      end
      if (val_we) begin
         val_mem[wr_slot] <= op_ff.value_in;
      end
      if (rank_we) begin
         rank_mem[rd_idx_ff] <= rank_wdata;
      end
   end

`ifndef ASSERT_OFF
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count differs from number of valid entries");

   a_req_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == S_SCAN))
      else $error("accepted request did not start a scan");

   a_rank_write_in_rank_pass: assert property (@(posedge clock) disable iff (reset)
      rank_we |-> (state_ff == S_RANK))
      else $error("rank write outside the rank pass");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.evicted) |-> !rsp_data_ff.hit)
      else $error("eviction reported on a hit");

   a_scan_hits_all_entries: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && scan_last) |-> rd_vld_ff)
      else $error("scan ended without the last entry read");
`endif

endmodule
